// ----- hdl/pepq_pkg.sv -----
// Shared types and constants for the presence phase event queue.
// Holds the action and register codes, the queue entry layout and the result record.
// Depends on nothing; every other file of the block refers to it by scoped names.
package pepq_pkg;

  // Default number of entries in the event queue.
  localparam int unsigned QUEUE_DEPTH_DEF = 64;

  // Milliseconds per second, used to turn a phase length into a limit.
  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  // Register reset values.
  localparam logic [15:0] TICK_PERIOD_RST = 16'd1000;
  localparam logic [15:0] OCCUPIED_RST    = 16'd10;
  localparam logic [15:0] EMPTY_RST       = 16'd5;

  // Codes of the request's action field.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_FAIL  = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_OCCUPIED    = 2'd1,
    CFG_EMPTY       = 2'd2
  } cfg_index_t;

  // Descriptive part of one queued event (its timestamp is stored separately).
  typedef struct packed {
    logic        dropped_before;
    logic        asserted;
    logic [31:0] sequence_num;
  } event_info_t;

  // One result record, as built by the control path.
  typedef struct packed {
    logic        event_valid;
    logic        event_asserted;
    logic [31:0] event_sequence;
    logic [63:0] event_time;
    logic        event_dropped_before;
    logic        presence_now;
    logic [31:0] current_sequence;
    logic [6:0]  queue_count;
    logic [31:0] total_count;
    logic [31:0] delivered_count;
    logic [31:0] dropped_count;
    logic [63:0] last_event_stamp;
  } result_t;

endpackage

// ----- hdl/presence_phase_event_queue.sv -----
// Top level of the presence phase event queue: control path, queue memories, output register.
// Depends on pepq_pkg, pepq_store and pepq_ctrl.
//
// Each request (tick, pop, clear statistics or delivery failure) yields exactly one result
// that carries the popped event, if any, and the status after the action. In the cycle a request
// is taken the head of the event memory is read; the execute step after it applies the action
// and loads the output register. No new request is taken until the execute step is done. A
// result waiting in the output register does not hold back the next request; only the execute
// step waits for the register to drain. No clearing pass is needed after reset. Configuration
// writes are always taken.
module presence_phase_event_queue #(
  parameter int unsigned QUEUE_DEPTH = pepq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Requests
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] stamp_ns
  input  logic [1:0]   in_tuser,   // [1:0] action
  // Results
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] event_valid, [32:1] event_sequence, [96:33] event_time,
  // [97] event_dropped_before, [98] presence_now, [130:99] current_sequence,
  // [137:131] queue_count, [169:138] total_count, [201:170] delivered_count,
  // [233:202] dropped_count, [297:234] last_event_stamp, [303:298] zero
  output logic [303:0] out_tdata,
  output logic [0:0]   out_tuser,  // [0] event_asserted
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  logic                  res_valid, res_ready;
  pepq_pkg::result_t     res;
  logic                  wr_en, rd_en;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  logic [63:0]           wr_time, rd_time;
  pepq_pkg::event_info_t wr_info, rd_info;

  logic                  out_valid_r;
  logic [303:0]          out_data_r;
  logic                  out_user_r;

  assign cfg_ready = 1'b1;

  pepq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_action (pepq_pkg::action_t'(in_tuser)),
    .req_stamp  (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_time    (wr_time),
    .wr_info    (wr_info),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_time    (rd_time),
    .rd_info    (rd_info)
  );

  pepq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_time (wr_time),
    .wr_info (wr_info),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_info (rd_info)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // Result payload, packed from the lowest bit up.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= {6'd0,
                     res.last_event_stamp,
                     res.dropped_count,
                     res.delivered_count,
                     res.total_count,
                     res.queue_count,
                     res.current_sequence,
                     res.presence_now,
                     res.event_dropped_before,
                     res.event_time,
                     res.event_sequence,
                     res.event_valid};
      out_user_r <= res.event_asserted;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule

// ----- hdl/pepq_store.sv -----
// Event queue storage: timestamp memory and descriptor memory sharing one address space.
// One write port and one registered read port each.
// Depends on pepq_pkg for the descriptor layout.
module pepq_store #(
  parameter int unsigned QUEUE_DEPTH = pepq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  logic [63:0]                    wr_time,
  input  pepq_pkg::event_info_t          wr_info,
  input  logic                           rd_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output logic [63:0]                    rd_time,
  output pepq_pkg::event_info_t          rd_info
);

  logic [63:0]           time_mem_r [QUEUE_DEPTH];
  pepq_pkg::event_info_t info_mem_r [QUEUE_DEPTH];
  logic [63:0]           rd_time_r;
  pepq_pkg::event_info_t rd_info_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem_r[wr_addr] <= wr_time;
      info_mem_r[wr_addr] <= wr_info;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_time_r <= time_mem_r[rd_addr];
      rd_info_r <= info_mem_r[rd_addr];
    end
  end

  assign rd_time = rd_time_r;
  assign rd_info = rd_info_r;

endmodule

// ----- hdl/pepq_ctrl.sv -----
// Control path: phase timer, queue pointers, statistics and configuration registers.
// Reads the queue head when a request is taken and applies the action in the execute state.
// Depends on pepq_pkg and drives the pepq_store memories.
module pepq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = pepq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request side
  input  logic                           req_valid,
  output logic                           req_ready,
  input  pepq_pkg::action_t              req_action,
  input  logic [63:0]                    req_stamp,
  // Configuration writes
  input  logic                           cfg_valid,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data,
  // Result hand-off to the output register
  output logic                           res_valid,
  input  logic                           res_ready,
  output pepq_pkg::result_t              res,
  // Queue memory ports
  output logic                           wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  output logic [63:0]                    wr_time,
  output pepq_pkg::event_info_t          wr_info,
  output logic                           rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  input  logic [63:0]                    rd_time,
  input  pepq_pkg::event_info_t          rd_info
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  pepq_pkg::action_t  action_r;
  logic [63:0]        stamp_r;

  logic [15:0]        tick_r, occ_r, emp_r;
  logic               presence_r, presence_nxt;
  logic [31:0]        elapsed_r, elapsed_nxt;
  logic [31:0]        seq_r, seq_nxt;
  logic               pend_r, pend_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [31:0]        total_r, total_nxt;
  logic [31:0]        deliv_r, deliv_nxt;
  logic [31:0]        dropcnt_r, dropcnt_nxt;
  logic [63:0]        last_r, last_nxt;

  logic               exec_go;
  logic [31:0]        elapsed_sum;
  logic [15:0]        phase_len;
  logic [25:0]        limit;
  logic               toggle;
  logic               full;
  logic               popped;
  logic [FILL_W+6:0]  fill_ext;

  function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] p);
    next_idx = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // A request is taken only in the idle state; the head entry is read at that edge.
  assign req_ready = (state_r == S_IDLE);
  assign rd_en     = req_valid && req_ready;
  assign rd_addr   = rd_ptr_r;
  assign exec_go   = (state_r == S_EXEC) && res_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req_valid) state_nxt = S_EXEC;
      S_EXEC: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Phase timer: elapsed time plus one tick against the limit of the current phase.
  assign elapsed_sum = elapsed_r + {16'd0, tick_r};
  assign phase_len   = presence_r ? occ_r : emp_r;
  assign limit       = {10'd0, phase_len} * {16'd0, pepq_pkg::MS_PER_SECOND};
  assign toggle      = !(elapsed_sum < {6'd0, limit});
  assign full        = (fill_r == FULL_CNT);

  // Apply the held action and build the result from the updated state.
  always_comb begin
    presence_nxt = presence_r;
    elapsed_nxt  = elapsed_r;
    seq_nxt      = seq_r;
    pend_nxt     = pend_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    fill_nxt     = fill_r;
    total_nxt    = total_r;
    deliv_nxt    = deliv_r;
    dropcnt_nxt  = dropcnt_r;
    last_nxt     = last_r;
    wr_en        = 1'b0;
    wr_info      = '{dropped_before: pend_r, asserted: !presence_r, sequence_num: seq_r + 1'b1};
    popped       = 1'b0;

    if (exec_go) begin
      unique case (action_r)
        pepq_pkg::ACT_TICK: begin
          if (toggle) begin
            presence_nxt = !presence_r;
            elapsed_nxt  = '0;
            seq_nxt      = seq_r + 1'b1;
            total_nxt    = total_r + 1'b1;
            last_nxt     = stamp_r;
            pend_nxt     = 1'b0;
            wr_en        = 1'b1;
            wr_ptr_nxt   = next_idx(wr_ptr_r);
            if (full) begin
              // Queue full: the oldest event is lost and the new one is flagged.
              rd_ptr_nxt          = next_idx(rd_ptr_r);
              dropcnt_nxt         = dropcnt_r + 1'b1;
              wr_info.dropped_before = 1'b1;
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
          end else begin
            elapsed_nxt = elapsed_sum;
          end
        end
        pepq_pkg::ACT_POP: begin
          if (fill_r != '0) begin
            popped     = 1'b1;
            rd_ptr_nxt = next_idx(rd_ptr_r);
            fill_nxt   = fill_r - 1'b1;
            deliv_nxt  = deliv_r + 1'b1;
          end
        end
        pepq_pkg::ACT_CLEAR: begin
          total_nxt   = '0;
          deliv_nxt   = '0;
          dropcnt_nxt = '0;
          last_nxt    = '0;
        end
        pepq_pkg::ACT_FAIL: begin
          dropcnt_nxt = dropcnt_r + 1'b1;
          pend_nxt    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign wr_addr  = wr_ptr_r;
  assign wr_time  = stamp_r;
  assign fill_ext = {7'd0, fill_nxt};

  // Result record; event fields stay zero unless a pop found an entry.
  assign res_valid                = (state_r == S_EXEC);
  assign res.event_valid          = popped;
  assign res.event_asserted       = popped & rd_info.asserted;
  assign res.event_sequence       = popped ? rd_info.sequence_num : 32'd0;
  assign res.event_time           = popped ? rd_time : 64'd0;
  assign res.event_dropped_before = popped & rd_info.dropped_before;
  assign res.presence_now         = presence_nxt;
  assign res.current_sequence     = seq_nxt;
  assign res.queue_count          = fill_ext[6:0];
  assign res.total_count          = total_nxt;
  assign res.delivered_count      = deliv_nxt;
  assign res.dropped_count        = dropcnt_nxt;
  assign res.last_event_stamp     = last_nxt;

  // Request capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      action_r <= req_action;
      stamp_r  <= req_stamp;
    end
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= pepq_pkg::TICK_PERIOD_RST;
      occ_r  <= pepq_pkg::OCCUPIED_RST;
      emp_r  <= pepq_pkg::EMPTY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pepq_pkg::CFG_TICK_PERIOD: tick_r <= cfg_data;
        pepq_pkg::CFG_OCCUPIED:    occ_r  <= cfg_data;
        pepq_pkg::CFG_EMPTY:       emp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control and statistics state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      presence_r <= 1'b0;
      elapsed_r  <= '0;
      seq_r      <= '0;
      pend_r     <= 1'b0;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      fill_r     <= '0;
      total_r    <= '0;
      deliv_r    <= '0;
      dropcnt_r  <= '0;
      last_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      presence_r <= presence_nxt;
      elapsed_r  <= elapsed_nxt;
      seq_r      <= seq_nxt;
      pend_r     <= pend_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      fill_r     <= fill_nxt;
      total_r    <= total_nxt;
      deliv_r    <= deliv_nxt;
      dropcnt_r  <= dropcnt_nxt;
      last_r     <= last_nxt;
    end
  end

  // Distance from read to write pointer, for the consistency check below.
  logic [PTR_W:0] ptr_gap;
  assign ptr_gap = (wr_ptr_r >= rd_ptr_r)
                 ? ({1'b0, wr_ptr_r} - {1'b0, rd_ptr_r})
                 : ({1'b0, wr_ptr_r} + (PTR_W + 1)'(QUEUE_DEPTH) - {1'b0, rd_ptr_r});

  // The fill count never goes past the queue depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("queue fill count beyond depth");

  // The pointers always agree with the fill count.
  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ptr_gap) == (full ? 32'd0 : 32'(fill_r)))
    else $error("queue pointers disagree with fill count");

  // A taken request puts the control in the execute state in the following cycle.
  a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == S_EXEC))
    else $error("taken request not executed");

  // A pop of a non-empty queue always returns an event.
  a_pop_event: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && action_r == pepq_pkg::ACT_POP && fill_r != '0) |-> res.event_valid)
    else $error("pop of a non-empty queue returned no event");

endmodule
